/* hw/rtl/aes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and byte functions for the AES-128 core
// S-box table, round constants, round-step and key-step functions.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned RoundW    = 4;

	localparam logic CfgKeyHigh = 1'b0;
	localparam logic CfgKeyLow  = 1'b1;
	localparam int unsigned CfgIdxW = 8;

	typedef logic [127:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
		8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
		8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
		8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
		8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
		8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
		8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
		8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
		8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
		8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
		8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
		8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
		8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
		8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
		8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
		8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
		8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
		8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
		8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
		8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
		8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
		8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
		8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
		8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
		8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
		8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
		8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
		8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
		8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
		8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
		8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
		8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
		8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
		8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
		8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
		8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
		8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
		8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
		8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
		8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
		8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
		8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
		8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
		8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
		8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
		8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
		8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
		8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
		8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
		8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
		8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
		8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
		8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
		8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
		8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
		8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
		8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
		8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
		8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
		8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
		8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
		8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
		8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
		8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
		8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
		default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
		logic [7:0] c;
		case (r)
		4'd0: c = 8'h01; 4'd1: c = 8'h02; 4'd2: c = 8'h04; 4'd3: c = 8'h08;
		4'd4: c = 8'h10; 4'd5: c = 8'h20; 4'd6: c = 8'h40; 4'd7: c = 8'h80;
		4'd8: c = 8'h1b; 4'd9: c = 8'h36;
		default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i sits at bits [127-8i -: 8]
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		return b[127 - 8*i -: 8];
	endfunction

	function automatic block_t next_key(input block_t k, input logic [RoundW-1:0] r);
		block_t o;
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		o = {w0, w1, w2, w3};
		return o;
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t o;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
			end
		end
		return o;
	endfunction

	function automatic block_t mix(input block_t s);
		block_t o;
		logic [7:0] a, b, c, d, x;
		for (int col = 0; col < 4; col++) begin
			a = get_byte(s, 4*col);
			b = get_byte(s, 4*col + 1);
			c = get_byte(s, 4*col + 2);
			d = get_byte(s, 4*col + 3);
			x = a ^ b ^ c ^ d;
			o[127 - 32*col -: 8]  = a ^ x ^ xtime(a ^ b);
			o[119 - 32*col -: 8]  = b ^ x ^ xtime(b ^ c);
			o[111 - 32*col -: 8]  = c ^ x ^ xtime(c ^ d);
			o[103 - 32*col -: 8]  = d ^ x ^ xtime(d ^ a);
		end
		return o;
	endfunction

endpackage

/* hw/rtl/aes128_block_encrypt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt: pipelined AES-128 block encryption
// Eleven register stages: key whitening, then one stage per cipher round.
// ----------------------------------------------------------------------------
// Usage: one plaintext beat may be issued on every cycle (busy is always low).
// Each beat's ciphertext is on cipher_high/cipher_low with done high for one
// cycle, after the beat has passed the initial key-add stage and the ten
// unrolled round stages; results leave in the order they were issued.
// The receiver cannot stall the pipeline, so results must be captured when
// done is high. Round keys travel with each block, so key_high/key_low
// (cfg index 0 and 1) may only be changed when no block is in flight; writes
// to other indexes are dropped. Keys reset to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [63:0]                    plain_high,
	input  logic [63:0]                    plain_low,
	output logic                           done,
	output logic [63:0]                    cipher_high,
	output logic [63:0]                    cipher_low,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [aes_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [63:0]                    cfg_data
);
	import aes_pkg::*;

	logic [63:0] key_high_q, key_low_q;

	// valid/state/key at every stage boundary: index 0 is after whitening
	logic   vld   [NumRounds+1];
	block_t state [NumRounds+1];
	block_t rkey  [NumRounds+1];

	logic   vld_s1;
	block_t state_s1, key_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold key registers; update only on a config beat to a known index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == {{(CfgIdxW-1){1'b0}}, CfgKeyHigh})
				key_high_q <= cfg_data;
			else if (cfg_index == {{(CfgIdxW-1){1'b0}}, CfgKeyLow})
				key_low_q <= cfg_data;
		end
	end

	// Stage 1: initial round-key add; carry the cipher key along.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		state_s1 <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
		key_s1   <= {key_high_q, key_low_q};
	end

	assign vld[0]   = vld_s1;
	assign state[0] = state_s1;
	assign rkey[0]  = key_s1;

	// Stages 2..11: one round each; the last round skips MixColumns.
	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		aes_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.round    (RoundW'(r)),
			.last     (r == NumRounds - 1),
			.vld_in   (vld[r]),
			.state_in (state[r]),
			.key_in   (rkey[r]),
			.vld_out  (vld[r+1]),
			.state_out(state[r+1]),
			.key_out  (rkey[r+1])
		);
	end

	assign done        = vld[NumRounds];
	assign cipher_high = state[NumRounds][127:64];
	assign cipher_low  = state[NumRounds][63:0];

endmodule

/* hw/rtl/aes_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round: one registered cipher round with its key-schedule step
// Takes state and previous round key, registers new state and round key.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [aes_pkg::RoundW-1:0]       round,
	input  logic                             last,
	input  logic                             vld_in,
	input  aes_pkg::block_t                  state_in,
	input  aes_pkg::block_t                  key_in,
	output logic                             vld_out,
	output aes_pkg::block_t                  state_out,
	output aes_pkg::block_t                  key_out
);
	import aes_pkg::*;

	block_t sb, mx, nk;

	always_comb begin
		sb = sub_shift(state_in);
		mx = last ? sb : mix(sb);
		nk = next_key(key_in, round);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	// payload advances every cycle; valid marks live beats
	always_ff @(posedge clk) begin
		state_out <= mx ^ nk;
		key_out   <= nk;
	end

endmodule

/* hw/rtl/aes_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker: port-level checks for the AES-128 pipeline
// Latency, issue matching, never-busy and config acceptance as seen at the top-level ports.
// ----------------------------------------------------------------------------
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);
	import aes_pkg::*;

	// every issued beat comes back after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(NumRounds + 1) done)
		else $error("result missing after fixed latency");

	// no result without a matching issue
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NumRounds + 1))
		else $error("result without matching start");

	// pipeline never blocks issue
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config beat refused");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
